// ----- hw/rtl/jhe_pkg.sv -----
// ----------------------------------------------------------------------------
// jhe_pkg
// Shared types, codes and constants of the joint histogram engine.
// ----------------------------------------------------------------------------
package jhe_pkg;

  localparam int unsigned MAX_RANGE_DEF   = 256;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam int unsigned VAL_W       = 8;
  localparam int unsigned RANGE_W     = 9;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned BIN_CNT_W   = 32;
  localparam int unsigned PROB_W      = 17;
  localparam int unsigned PROB_FRAC_W = 16;
  localparam int unsigned ADDR_FULL_W = 2 * VAL_W + 1;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [RANGE_W-1:0] RANGE_RST = 9'd256;
  localparam logic [TOTAL_W-1:0] TOTAL_RST = 32'd1;
  localparam logic [PROB_W-1:0]  PROB_ONE  = 17'h10000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FIRST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SECOND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SAMPLES = 2'd2;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } jhe_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_SAT   = 2'd2
  } jhe_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_PROB,
    S_DIV,
    S_DONE
  } jhe_state_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [VAL_W-1:0] value_first;
    logic [VAL_W-1:0] value_second;
  } jhe_in_t;

  typedef struct packed {
    logic [BIN_CNT_W-1:0] bin_count;
    logic [PROB_W-1:0]    probability;
    logic [1:0]           status;
  } jhe_out_t;

endpackage

// ----- hw/rtl/joint_histogram_engine_unit.sv -----
// ----------------------------------------------------------------------------
// joint_histogram_engine_unit
// Joint histogram of two feature streams: add, read and clear of count bins,
// with count/total probability in unsigned Q1.16.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_stall_o   jhe_in_t  (cmd, value pair)
//  out       output     out_valid_o / out_stall_i jhe_out_t (count, prob, status)
//  cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  One transaction at a time. An in-range add or read goes through bin read,
//  update and write-back, then the bit-serial probability divider; a count at
//  or above the total skips the divider. Out-of-range and unused commands go
//  straight to the result. Clear sweeps the bin memory, one entry per cycle;
//  reset runs the same sweep.
//  A waiting result sits in the output register while the next one is taken.
// ----------------------------------------------------------------------------
module joint_histogram_engine_unit import jhe_pkg::*; #(
  parameter int unsigned MAX_RANGE   = MAX_RANGE_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  jhe_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output jhe_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH = MAX_RANGE * MAX_RANGE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CMPW  = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

  jhe_state_e state_q, state_d;

  logic [RANGE_W-1:0]     range_first_q, range_second_q;
  logic [TOTAL_W-1:0]     total_q;
  logic [RANGE_W-1:0]     rf_eff, rs_eff;
  logic [TOTAL_W-1:0]     div_eff;
  logic [ADDR_FULL_W-1:0] addr_full;
  logic [AW-1:0]          addr_in;
  logic                   in_range;
  logic                   is_count_cmd;

  logic [AW-1:0]          clr_addr_q, clr_addr_d;
  logic                   clr_cmd_q, clr_cmd_d;
  logic [1:0]             cmd_q, cmd_d;
  logic [AW-1:0]          addr_q, addr_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [PROB_W-1:0]      prob_q, prob_d;
  jhe_status_e            status_q, status_d;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                   div_start, div_done;
  logic [PROB_FRAC_W-1:0] div_quot;
  logic                   count_ge;
  logic                   out_valid_q;
  jhe_out_t               out_q;
  logic                   out_load;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_first_q  <= RANGE_RST;
      range_second_q <= RANGE_RST;
      total_q        <= TOTAL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RANGE_FIRST:   range_first_q  <= cfg_data_i[RANGE_W-1:0];
        CFG_RANGE_SECOND:  range_second_q <= cfg_data_i[RANGE_W-1:0];
        CFG_TOTAL_SAMPLES: total_q        <= cfg_data_i[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp ranges to the store geometry
  assign rf_eff  = (32'(range_first_q) > 32'(MAX_RANGE)) ? RANGE_W'(MAX_RANGE)
                                                         : range_first_q;
  assign rs_eff  = (32'(range_second_q) > 32'(MAX_RANGE)) ? RANGE_W'(MAX_RANGE)
                                                          : range_second_q;
  assign div_eff = (total_q == '0) ? TOTAL_W'(1) : total_q;

  assign in_range = ({1'b0, in_data_i.value_first} < rf_eff) &&
                    ({1'b0, in_data_i.value_second} < rs_eff);
  assign is_count_cmd = (in_data_i.cmd == CMD_ADD) || (in_data_i.cmd == CMD_READ);
  assign addr_full = ({9'b0, in_data_i.value_first} * {8'b0, rs_eff}) +
                     {9'b0, in_data_i.value_second};
  assign addr_in   = AW'(addr_full);

  assign count_ge   = CMPW'(count_q) >= CMPW'(div_eff);
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          state_d = clr_cmd_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.cmd == CMD_CLEAR) begin
            state_d = S_CLEAR;
          end else if (is_count_cmd && in_range) begin
            state_d = S_CALC;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_CALC: state_d = S_PROB;
      S_PROB: state_d = count_ge ? S_DONE : S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_cmd_d  = clr_cmd_q;
    cmd_d      = cmd_q;
    addr_d     = addr_q;
    count_d    = count_q;
    prob_d     = prob_q;
    status_d   = status_q;
    ram_we     = 1'b0;
    ram_waddr  = addr_q;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    div_start  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        clr_addr_d = (clr_addr_q == AW'(DEPTH - 1)) ? '0 : clr_addr_q + AW'(1);
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ram_re   = 1'b1;
          cmd_d    = in_data_i.cmd;
          addr_d   = addr_in;
          count_d  = '0;
          prob_d   = '0;
          status_d = STAT_OK;
          if (in_data_i.cmd == CMD_CLEAR) begin
            clr_cmd_d  = 1'b1;
            clr_addr_d = '0;
          end else if (is_count_cmd && !in_range) begin
            status_d = STAT_RANGE;
          end
        end
      end
      S_CALC: begin
        count_d = ram_rdata;
        if (cmd_q == CMD_ADD) begin
          ram_we = 1'b1;
          if (ram_rdata == '1) begin
            // hold the count at its maximum
            status_d  = STAT_SAT;
            ram_wdata = ram_rdata;
          end else begin
            count_d   = ram_rdata + COUNT_WIDTH'(1);
            ram_wdata = ram_rdata + COUNT_WIDTH'(1);
          end
        end
      end
      S_PROB: begin
        if (count_ge) begin
          prob_d = PROB_ONE;
        end else begin
          div_start = 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          prob_d = {1'b0, div_quot};
        end
      end
      S_DONE: begin
        if (out_load) begin
          clr_cmd_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      clr_cmd_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      clr_cmd_q  <= clr_cmd_d;
      if (state_q == S_DONE && out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    addr_q   <= addr_d;
    count_q  <= count_d;
    prob_q   <= prob_d;
    status_q <= status_d;
    if (state_q == S_DONE && out_load) begin
      out_q.bin_count   <= BIN_CNT_W'(count_q);
      out_q.probability <= prob_q;
      out_q.status      <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  jhe_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_bin_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_in),
    .rdata_o (ram_rdata)
  );

  // count is below the divisor here, so its low word is exact
  jhe_div #(
    .NUM_W  (TOTAL_W),
    .QUOT_W (PROB_FRAC_W)
  ) u_prob_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (TOTAL_W'(count_q)),
    .den_i   (div_eff),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

endmodule

// ----- hw/rtl/jhe_ram.sv -----
// ----------------------------------------------------------------------------
// jhe_ram
// Generic memory, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jhe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/jhe_div.sv -----
// ----------------------------------------------------------------------------
// jhe_div
// Bit-serial restoring divider for a fraction num/den with num below den:
// one quotient bit per cycle, and done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module jhe_div import jhe_pkg::*; #(
  parameter int unsigned NUM_W  = TOTAL_W,
  parameter int unsigned QUOT_W = PROB_FRAC_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [NUM_W-1:0]  den_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  den_q, den_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [NUM_W:0]    shifted;
  logic [NUM_W:0]    diff;
  logic              fits;
  logic              last;

  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};
  assign last    = busy_q && (cnt_q == CNT_W'(1));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    done_d = last;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUOT_W);
      rem_d  = num_i;
      den_d  = den_i;
      quot_d = '0;
    end else if (busy_q) begin
      cnt_d  = cnt_q - CNT_W'(1);
      // remainder stays below den, so the dropped top bit is zero
      rem_d  = fits ? diff[NUM_W-1:0] : shifted[NUM_W-1:0];
      quot_d = {quot_q[QUOT_W-2:0], fits};
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the joint histogram engine. A short table of
// directed transactions (reset state, range edges, clear, unused command)
// is followed by random phases, each with its own range and total-sample
// setting. A bin-count model predicts every result, and a queue of expected
// bin results is matched in order against the output channel, with random
// gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb import jhe_pkg::*; ();

  localparam int unsigned        CLK_HALF     = 6;
  localparam int unsigned        RST_CYCLES   = 3;
  localparam int unsigned        DRAIN_PAUSE  = 32;
  localparam int unsigned        CYCLE_LIMIT  = 2000000;
  localparam int unsigned        RAND_PHASES  = 12;
  localparam int unsigned        PHASE_ITEMS  = 142;
  localparam logic [1:0]         CMD_NONE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint unsigned    CNT_MAX      = (64'd1 << COUNT_WIDTH_DEF) - 64'd1;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    jhe_in_t               item;
    bit                    typed;
    jhe_out_t              want;
  } stim_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  jhe_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  jhe_out_t              out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // model state and configuration
  longint unsigned       hist_bins [int unsigned];
  logic [RANGE_W-1:0]    rng_first  = RANGE_RST;
  logic [RANGE_W-1:0]    rng_second = RANGE_RST;
  logic [TOTAL_W-1:0]    total_cnt  = TOTAL_RST;

  jhe_out_t              pending_q [$];
  stim_row_t             dir_tab [$];
  int unsigned           n_errors  = 0;
  int unsigned           n_sent    = 0;
  int unsigned           n_checked = 0;
  int unsigned           n_clears  = 0;
  int unsigned           n_writes  = 0;
  int unsigned           cycles    = 0;
  int unsigned           stall_left = 0;
  bit                    tx_calm   = 1'b0;
  bit                    rx_calm   = 1'b0;

  joint_histogram_engine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned eff_range(logic [RANGE_W-1:0] r);
    return (r > MAX_RANGE_DEF) ? MAX_RANGE_DEF : int'(r);
  endfunction

  // update the bin model for one transaction and return its result
  function automatic jhe_out_t predict_bin(jhe_in_t it);
    jhe_out_t        res;
    int unsigned     rf, rs, addr;
    longint unsigned cnt, div, prob;
    res = '0;
    rf  = eff_range(rng_first);
    rs  = eff_range(rng_second);
    case (it.cmd)
      CMD_CLEAR: begin
        hist_bins.delete();
        n_clears++;
      end
      CMD_ADD, CMD_READ: begin
        if (it.value_first >= rf || it.value_second >= rs) begin
          res.status = STAT_RANGE;
        end else begin
          addr = it.value_first * rs + it.value_second;
          cnt  = hist_bins.exists(addr) ? hist_bins[addr] : 64'd0;
          if (it.cmd == CMD_ADD) begin
            if (cnt >= CNT_MAX) begin
              cnt        = CNT_MAX;
              res.status = STAT_SAT;
            end else begin
              cnt++;
            end
            hist_bins[addr] = cnt;
          end
          div  = (total_cnt == 0) ? 64'd1 : 64'(total_cnt);
          prob = (cnt >= div) ? 64'(PROB_ONE) : ((cnt << PROB_FRAC_W) / div);
          res.bin_count   = cnt[BIN_CNT_W-1:0];
          res.probability = prob[PROB_W-1:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic stim_row_t row_item(logic [1:0] c, int unsigned vf, int unsigned vs);
    stim_row_t r;
    r = '{default: '0};
    r.item.cmd          = c;
    r.item.value_first  = vf[VAL_W-1:0];
    r.item.value_second = vs[VAL_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t row_exp(logic [1:0] c, int unsigned vf, int unsigned vs,
                                        int unsigned cnt, int unsigned prob, logic [1:0] st);
    stim_row_t r;
    r = row_item(c, vf, vs);
    r.typed            = 1'b1;
    r.want.bin_count   = cnt;
    r.want.probability = prob[PROB_W-1:0];
    r.want.status      = st;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = d;
    return r;
  endfunction

  // present one transaction, hold it until taken, then idle for the requested gap
  task automatic send_item(jhe_in_t it, bit typed, jhe_out_t want, int unsigned gap);
    jhe_out_t pred;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    pred = predict_bin(it);
    pending_q.push_back(typed ? want : pred);
    n_sent++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending and wait until every expected result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAUSE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_RANGE_FIRST:   rng_first  = d[RANGE_W-1:0];
      CFG_RANGE_SECOND:  rng_second = d[RANGE_W-1:0];
      CFG_TOTAL_SAMPLES: total_cnt  = d;
      default: ;
    endcase
    n_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // output-side stall pattern
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (rx_calm) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_left  <= pick_gap();
    end
  end

  // compare each delivered result with the oldest expectation
  always @(posedge clk_i) begin
    jhe_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result count=%0d prob=%0d status=%0d", $time,
                 out_data_o.bin_count, out_data_o.probability, out_data_o.status);
      end else begin
        want = pending_q.pop_front();
        n_checked++;
        if (out_data_o.bin_count !== want.bin_count ||
            out_data_o.probability !== want.probability ||
            out_data_o.status !== want.status) begin
          n_errors++;
          $display("%0t: result mismatch exp count=%0d prob=%0d status=%0d,",
                   $time, want.bin_count, want.probability, want.status);
          $display("%0t:   act count=%0d prob=%0d status=%0d",
                   $time, out_data_o.bin_count, out_data_o.probability, out_data_o.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d results outstanding", $time, pending_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    jhe_in_t               it;
    jhe_out_t              none;
    logic [CFG_DATA_W-1:0] d;
    int unsigned           r, ef_f, ef_s, clears_left, gap;

    none        = '0;
    clears_left = 2;

    // after reset, then range edges, unused command, clear, degenerate divisors
    dir_tab.push_back(row_exp(CMD_READ,    0,   0, 0, 0, STAT_OK));
    dir_tab.push_back(row_exp(CMD_READ,  255, 255, 0, 0, STAT_OK));
    dir_tab.push_back(row_exp(CMD_ADD,     0,   0, 1, 32'h10000, STAT_OK));
    dir_tab.push_back(row_exp(CMD_ADD,   255, 255, 1, 32'h10000, STAT_OK));
    dir_tab.push_back(row_exp(CMD_ADD,     0,   0, 2, 32'h10000, STAT_OK));
    dir_tab.push_back(row_item(CMD_READ,   0,   0));
    dir_tab.push_back(row_exp(CMD_NONE,  255, 255, 0, 0, STAT_OK));
    dir_tab.push_back(row_exp(CMD_CLEAR, 255, 255, 0, 0, STAT_OK));
    dir_tab.push_back(row_exp(CMD_READ,    0,   0, 0, 0, STAT_OK));
    dir_tab.push_back(row_exp(CMD_READ,  255, 255, 0, 0, STAT_OK));
    dir_tab.push_back(row_cfg(CFG_RANGE_FIRST, 32'd3));
    dir_tab.push_back(row_cfg(CFG_RANGE_SECOND, 32'd5));
    dir_tab.push_back(row_cfg(CFG_TOTAL_SAMPLES, 32'd7));
    dir_tab.push_back(row_exp(CMD_ADD,     3,   0, 0, 0, STAT_RANGE));
    dir_tab.push_back(row_exp(CMD_READ,    0,   5, 0, 0, STAT_RANGE));
    dir_tab.push_back(row_item(CMD_ADD,    2,   4));
    dir_tab.push_back(row_item(CMD_ADD,    2,   4));
    dir_tab.push_back(row_item(CMD_READ,   2,   4));
    dir_tab.push_back(row_cfg(CFG_RANGE_FIRST, 32'd0));
    dir_tab.push_back(row_exp(CMD_ADD,     0,   0, 0, 0, STAT_RANGE));
    dir_tab.push_back(row_cfg(CFG_RANGE_FIRST, 32'd511));
    dir_tab.push_back(row_cfg(CFG_RANGE_SECOND, 32'd0));
    dir_tab.push_back(row_exp(CMD_READ,    0,   0, 0, 0, STAT_RANGE));
    dir_tab.push_back(row_cfg(CFG_RANGE_SECOND, 32'd300));
    dir_tab.push_back(row_cfg(CFG_TOTAL_SAMPLES, 32'd0));
    dir_tab.push_back(row_exp(CMD_ADD,   255, 255, 1, 32'h10000, STAT_OK));
    dir_tab.push_back(row_cfg(CFG_TOTAL_SAMPLES, 32'hFFFF_FFFF));
    dir_tab.push_back(row_item(CMD_READ, 255, 255));
    dir_tab.push_back(row_cfg(CFG_UNUSED, 32'hFFFF_FFFF));
    dir_tab.push_back(row_cfg(CFG_RANGE_FIRST, 32'd1));
    dir_tab.push_back(row_cfg(CFG_RANGE_SECOND, 32'd1));
    dir_tab.push_back(row_item(CMD_ADD,    0,   0));
    dir_tab.push_back(row_exp(CMD_ADD,     0,   1, 0, 0, STAT_RANGE));
    dir_tab.push_back(row_item(CMD_READ,   0,   0));

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain_results();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want, pick_gap());
      end
    end

    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      for (int unsigned k = 0; k < 3; k++) begin
        d = $urandom();
        if (k == CFG_TOTAL_SAMPLES) begin
          r = $urandom_range(0, 99);
          if (r < 10)      d = 32'd0;
          else if (r < 15) d = 32'hFFFF_FFFF;
          else if (r < 60) d = $urandom_range(1, 20);
          else if (r < 85) d = $urandom_range(21, 1000);
        end else begin
          // small ranges keep the bins busy; a few zero or oversized settings
          r = $urandom_range(0, 99);
          if (r < 5)       d[RANGE_W-1:0] = 9'd0;
          else if (r < 10) d[RANGE_W-1:0] = RANGE_W'($urandom_range(257, 511));
          else if (r < 15) d[RANGE_W-1:0] = 9'd256;
          else if (r < 70) d[RANGE_W-1:0] = RANGE_W'($urandom_range(1, 8));
          else             d[RANGE_W-1:0] = RANGE_W'($urandom_range(1, 256));
        end
        write_reg(k[CFG_IDX_W-1:0], d);
      end
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      ef_f = eff_range(rng_first);
      ef_s = eff_range(rng_second);

      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 999);
        it.value_first  = VAL_W'($urandom_range(0, 255));
        it.value_second = VAL_W'($urandom_range(0, 255));
        if (r < 850 && ef_f != 0 && ef_s != 0) begin
          it.cmd          = (r < 600) ? CMD_ADD : CMD_READ;
          it.value_first  = VAL_W'($urandom_range(0, ef_f - 1));
          it.value_second = VAL_W'($urandom_range(0, ef_s - 1));
        end else if (r < 950) begin
          it.cmd = 2'($urandom_range(0, 1));
        end else if (r >= 997 && clears_left != 0) begin
          it.cmd = CMD_CLEAR;
          clears_left--;
        end else begin
          it.cmd = CMD_NONE;
        end
        gap = tx_calm ? 0 : pick_gap();
        send_item(it, 1'b0, none, gap);
        // hold off now and then until the engine is empty
        if ($urandom_range(0, 199) == 0) drain_results();
      end
    end

    drain_results();
    $display("%0d transactions sent, %0d results checked, %0d clears, %0d register writes",
             n_sent, n_checked, n_clears, n_writes);
    $display("covered: range edges, zero and full divisor, random phases with gaps and stalls");
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
